@@ hdl/epwpe_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// epwpe_pkg
// Shared types and constants for the e-paper waveform pixel encoder.
// ---------------------------------------------------------------------------
package epwpe_pkg;

  localparam int unsigned TableBytesDefault = 64;
  localparam int unsigned CfgIdxW           = 2;
  localparam int unsigned CfgDataW          = 8;
  localparam int unsigned Lanes             = 4;

  typedef enum logic [0:0] {
    OpConvert = 1'b0,
    OpLoad    = 1'b1
  } op_e;

  // Code 3 is undefined and encodes to all zeros.
  typedef enum logic [1:0] {
    ModeDiff  = 2'd0,
    ModeFixed = 2'd1,
    ModeMono  = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPackMode  = 2'd0,
    CfgFixedFrom = 2'd1
  } cfg_idx_e;

  localparam logic [3:0] FixedFromReset = 4'hF;

  typedef struct packed {
    op_e         op;
    logic [5:0]  table_index;
    logic [7:0]  table_byte;
    logic [31:0] pixel_word;
    logic        line_end;
  } in_t;

  typedef struct packed {
    logic [31:0] drive_bits;
    logic        line_end_out;
  } out_t;

endpackage
`default_nettype wire

@@ hdl/epwpe_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// epwpe_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module epwpe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ hdl/epaper_waveform_pixel_encoder.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// epaper_waveform_pixel_encoder
// Converts pixel words into two-bit e-paper drive codes via a waveform table.
// ---------------------------------------------------------------------------
// One item is accepted per cycle while in_stall_o is low, and a convert item's
// result is presented in two steps: the first reads four phase bytes from the
// waveform table, the second picks the phases and loads the output register.
// The table is held in four identical RAM copies, written together by load
// transactions and each read at one address per table-mode convert, which is
// what gives four table lookups per word at one word per cycle while the input
// is not stalled. Load transactions write one table byte and produce no result.
// A load followed directly by a convert sees the new byte. Table bytes read
// before they are written give undefined drive codes. Configuration (pack mode,
// fixed from color) is written through its own port, ready every cycle, and
// must only change while the pipeline is empty.
// ---------------------------------------------------------------------------
module epaper_waveform_pixel_encoder
  import epwpe_pkg::*;
#(
  parameter int unsigned TABLE_BYTES = TableBytesDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // item input
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_t                 in_data_i,
  // result output
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_t                     out_data_o,
  // configuration writes
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;

  // Phase for from-color low bits: first from color sits in bits 7:6.
  function automatic logic [1:0] phase_pick(logic [7:0] b, logic [1:0] f);
    logic [1:0] r;
    case (f)
      2'd0:    r = b[7:6];
      2'd1:    r = b[5:4];
      2'd2:    r = b[3:2];
      default: r = b[1:0];
    endcase
    return r;
  endfunction

  // ---------------- configuration ----------------
  mode_e      pack_mode_q;
  logic [3:0] fixed_from_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_mode_q  <= ModeDiff;
      fixed_from_q <= FixedFromReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgPackMode:  pack_mode_q  <= mode_e'(cfg_data_i[1:0]);
        CfgFixedFrom: fixed_from_q <= cfg_data_i[3:0];
        default:      ;  // unmapped index: ignored
      endcase
    end
  end

  // ---------------- handshake control ----------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_ready, s1_adv;
  logic in_acc, cvt_acc, load_acc, ram_re;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cvt_acc    = in_acc && (in_data_i.op == OpConvert);
  assign load_acc   = in_acc && (in_data_i.op == OpLoad);
  // Only table-based modes need lookups.
  assign ram_re     = cvt_acc && ((pack_mode_q == ModeDiff) || (pack_mode_q == ModeFixed));

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (cvt_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------- lookup addresses ----------------
  // Lane k produces drive bits 2k+1:2k.
  logic [AddrW-1:0] raddr [Lanes];
  logic [1:0]       sel_d [Lanes];

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      logic [7:0] pb;
      pb = in_data_i.pixel_word[(24 - 8*k) +: 8];
      if (pack_mode_q == ModeFixed) begin
        raddr[k] = AddrW'({in_data_i.pixel_word[4*k +: 4], fixed_from_q[3:2]});
        sel_d[k] = fixed_from_q[1:0];
      end else begin
        // difference mode: to in high nibble, from in low nibble
        raddr[k] = AddrW'({pb[7:4], pb[3:2]});
        sel_d[k] = pb[1:0];
      end
    end
  end

  // ---------------- table copies ----------------
  logic [7:0] rdata [Lanes];

  for (genvar g = 0; g < Lanes; g++) begin : g_tbl
    epwpe_ram #(
      .Width (8),
      .Depth (TABLE_BYTES)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (load_acc),
      .waddr_i (AddrW'(in_data_i.table_index)),
      .wdata_i (in_data_i.table_byte),
      .re_i    (ram_re),
      .raddr_i (raddr[g]),
      .rdata_o (rdata[g])
    );
  end

  // ---------------- stage 1 payload ----------------
  mode_e       s1_mode_q;
  logic [1:0]  s1_sel_q [Lanes];
  logic [15:0] s1_mono_q;
  logic        s1_line_end_q;

  always_ff @(posedge clk_i) begin
    if (cvt_acc) begin
      s1_mode_q     <= pack_mode_q;
      s1_sel_q      <= sel_d;
      s1_mono_q     <= in_data_i.pixel_word[15:0];
      s1_line_end_q <= in_data_i.line_end;
    end
  end

  // ---------------- encode ----------------
  logic [31:0] drive_d;

  always_comb begin
    drive_d = '0;
    case (s1_mode_q)
      ModeDiff, ModeFixed: begin
        for (int k = 0; k < Lanes; k++) begin
          drive_d[2*k +: 2] = phase_pick(rdata[k], s1_sel_q[k]);
        end
      end
      ModeMono: begin
        // set bit -> 00, clear bit -> 01; low byte lands in the upper half
        for (int b = 0; b < 8; b++) begin
          drive_d[16 + 2*b +: 2] = {1'b0, ~s1_mono_q[b]};
          drive_d[2*b +: 2]      = {1'b0, ~s1_mono_q[8 + b]};
        end
      end
      default: drive_d = '0;
    endcase
  end

  out_t out_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.drive_bits   <= drive_d;
      out_q.line_end_out <= s1_line_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  // A stalled stage 1 must not see its lookup data overwritten.
  a_no_read_while_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> !(s1_valid_q && !out_ready))
    else $error("table read issued while stage 1 is held");

  // Input stalls only when both stages are full.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with pipeline space");

  // A load never creates a result in stage 1.
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_acc && !s1_valid_q) |=> !s1_valid_q)
    else $error("load transaction produced a result");

  // A new result only comes from a filled stage 1.
  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without stage 1 data");

endmodule
`default_nettype wire
